// File: rtl/core/binary_grid_cellular_smoothing_macros.svh
// assertion helpers shared by the smoothing core
`ifndef BINARY_GRID_CELLULAR_SMOOTHING_MACROS_SVH
`define BINARY_GRID_CELLULAR_SMOOTHING_MACROS_SVH

// same-cycle implication
`define BGCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BGCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/bgcs_pkg.sv
`timescale 1ns / 1ps

package bgcs_pkg;

   // register indexes of the csr port
   localparam logic [2:0] CSR_GRID_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_GRID_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_DEATH_BELOW  = 3'd2;
   localparam logic [2:0] CSR_BIRTH_ABOVE  = 3'd3;
   localparam logic [2:0] CSR_FORCE_BORDER = 3'd4;

   localparam logic [8:0] GRID_WIDTH_RESET   = 9'd64;
   localparam logic [8:0] GRID_HEIGHT_RESET  = 9'd64;
   localparam logic [3:0] DEATH_BELOW_RESET  = 4'd5;
   localparam logic [3:0] BIRTH_ABOVE_RESET  = 4'd4;
   localparam logic       FORCE_BORDER_RESET = 1'b1;

   // per-item description passed from the front to the result side
   // bit 0: upper-left cell, bit 1: cell above, bit 2: the cell itself
   typedef struct packed {
      logic [2:0] emit;
      logic [2:0] wall;
      logic       frame_end;
   } item_info_type;

endpackage

// File: rtl/core/bgcs_front.sv
`timescale 1ns / 1ps

module bgcs_front #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int CW         = 8,
   parameter int RW         = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [8:0]             csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cell_in_wall,
   input  logic                   queue_room,
   output logic                   push,
   output bgcs_pkg::item_info_type push_info,
   output logic [CW-1:0]          push_col,
   output logic [RW-1:0]          push_row
);
   import bgcs_pkg::*;

   logic [8:0] width_ff;
   logic [8:0] height_ff;
   logic [3:0] death_ff;
   logic [3:0] birth_ff;
   logic       border_ff;

   logic [CW-1:0] last_col;
   logic [RW-1:0] last_row;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic [1:0]    line_mem [MAX_WIDTH];
   logic [1:0]    rd_ff;

   logic          s1_valid_ff;
   logic          s1_x_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic [5:0]    window_ff, window_in;

   logic          csr_write;
   logic          restart;
   logic          take;
   logic [2:0]    newcol;
   logic [3:0]    win_count;
   logic          at_last_col;
   logic          at_last_row;
   logic          first_border;
   logic          center;
   logic          v_first;
   item_info_type info;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign restart   = csr_write &
                      ((csr_index == CSR_GRID_WIDTH) || (csr_index == CSR_GRID_HEIGHT));

   assign req_ready = queue_room;
   assign take      = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= GRID_WIDTH_RESET;
         height_ff <= GRID_HEIGHT_RESET;
         death_ff  <= DEATH_BELOW_RESET;
         birth_ff  <= BIRTH_ABOVE_RESET;
         border_ff <= FORCE_BORDER_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GRID_WIDTH:   width_ff  <= csr_data;
            CSR_GRID_HEIGHT:  height_ff <= csr_data;
            CSR_DEATH_BELOW:  death_ff  <= csr_data[3:0];
            CSR_BIRTH_ABOVE:  birth_ff  <= csr_data[3:0];
            CSR_FORCE_BORDER: border_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // sizes clamped to 3..max
   always_comb begin
      if (width_ff < 9'd3) begin
         last_col = CW'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         last_col = CW'(MAX_WIDTH - 1);
      end else begin
         last_col = CW'(width_ff - 9'd1);
      end
      if (height_ff < 9'd3) begin
         last_row = RW'(2);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         last_row = RW'(MAX_HEIGHT - 1);
      end else begin
         last_row = RW'(height_ff - 9'd1);
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == last_row) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         window_ff   <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= take;
         window_ff   <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_x_ff   <= req_cell_in_wall;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
      end
   end

   // line memory: bit 1 row above, bit 0 two rows above
   always_ff @(posedge clock) begin
      if (take) begin
         rd_ff <= line_mem[col_ff];
      end
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= {s1_x_ff, rd_ff[1]};
      end
   end

   assign newcol = {s1_x_ff, rd_ff};
   assign win_count = 4'(window_ff[0]) + 4'(window_ff[1]) + 4'(window_ff[2]) +
                      4'(window_ff[3]) + 4'(window_ff[4]) + 4'(window_ff[5]) +
                      4'(newcol[0]) + 4'(newcol[1]) + 4'(newcol[2]);

   assign at_last_col  = (s1_col_ff == last_col);
   assign at_last_row  = (s1_row_ff == last_row);
   assign first_border = (s1_row_ff == RW'(1)) || (s1_col_ff == CW'(1));
   assign center       = window_ff[4];

   always_comb begin
      if (first_border) begin
         v_first = border_ff | center;
      end else if (center) begin
         v_first = !(win_count < death_ff);
      end else begin
         v_first = (win_count > birth_ff);
      end
   end

   always_comb begin
      info.emit[0]   = (s1_row_ff != '0) && (s1_col_ff != '0);
      info.emit[1]   = (s1_row_ff != '0) && at_last_col;
      info.emit[2]   = at_last_row;
      info.wall[0]   = v_first;
      info.wall[1]   = border_ff | rd_ff[1];
      info.wall[2]   = border_ff | s1_x_ff;
      info.frame_end = at_last_col && at_last_row;
   end

   // window slides by one column, cleared at the row end
   always_comb begin
      window_in = window_ff;
      if (restart) begin
         window_in = '0;
      end else if (s1_valid_ff) begin
         window_in = at_last_col ? 6'd0 : {newcol, window_ff[5:3]};
      end
   end

   assign push      = s1_valid_ff && (info.emit != 3'b000);
   assign push_info = info;
   assign push_col  = s1_col_ff;
   assign push_row  = s1_row_ff;

endmodule

// File: rtl/core/bgcs_fifo.sv
`timescale 1ns / 1ps
`include "binary_grid_cellular_smoothing_macros.svh"

module bgcs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data,
   output logic             room
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [NW-1:0]    count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = store_ff[rd_ptr_ff];
   // two free slots: one for the item in flight, one for the new beat
   assign room       = (count_ff <= NW'(DEPTH - 2));

   `BGCS_ASSERT_IMPL(a_no_overflow, clock, reset, push && !pop, count_ff != NW'(DEPTH), "push into full queue")
   `BGCS_ASSERT_IMPL(a_no_underflow, clock, reset, pop, count_ff != '0, "pop from empty queue")
   `BGCS_ASSERT_NEXT(a_count_bound, clock, reset, 1'b1, count_ff <= NW'(DEPTH), "queue count out of range")

endmodule

// File: rtl/core/bgcs_back.sv
`timescale 1ns / 1ps
`include "binary_grid_cellular_smoothing_macros.svh"

module bgcs_back #(
   parameter int CW = 8,
   parameter int RW = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  bgcs_pkg::item_info_type head_info,
   input  logic [CW-1:0]           head_col,
   input  logic [RW-1:0]           head_row,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_cell_out_wall,
   output logic [7:0]              rsp_out_col,
   output logic [7:0]              rsp_out_row,
   output logic                    rsp_last_of_run,
   output logic                    rsp_frame_done
);
   import bgcs_pkg::*;

   logic          rsp_valid_ff;
   logic          wall_ff;
   logic [7:0]    col_ff;
   logic [7:0]    row_ff;
   logic          last_ff;
   logic          done_frame_ff;
   logic [2:0]    sent_ff;

   logic [2:0]    remaining;
   logic [2:0]    pick;
   logic          last;
   logic          load;
   logic [CW-1:0] sel_col;
   logic [RW-1:0] sel_row;
   logic [CW+7:0] col_ext;
   logic [RW+7:0] row_ext;

   assign remaining = head_info.emit & ~sent_ff;

   always_comb begin
      if (remaining[0]) begin
         pick = 3'b001;
      end else if (remaining[1]) begin
         pick = 3'b010;
      end else begin
         pick = 3'b100;
      end
   end

   assign last = ((remaining & ~pick) == 3'b000);
   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && last;

   assign sel_col = pick[0] ? head_col - 1'b1 : head_col;
   assign sel_row = pick[2] ? head_row : head_row - 1'b1;
   assign col_ext = {8'b0, sel_col};
   assign row_ext = {8'b0, sel_row};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sent_ff      <= '0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         sent_ff      <= last ? 3'b000 : (sent_ff | pick);
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         wall_ff       <= |(pick & head_info.wall);
         col_ff        <= col_ext[7:0];
         row_ff        <= row_ext[7:0];
         last_ff       <= last;
         done_frame_ff <= last && head_info.frame_end;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_out_wall = wall_ff;
   assign rsp_out_col       = col_ff;
   assign rsp_out_row       = row_ff;
   assign rsp_last_of_run   = last_ff;
   assign rsp_frame_done    = done_frame_ff;

   `BGCS_ASSERT_IMPL(a_frame_on_last, clock, reset, rsp_valid_ff && done_frame_ff, last_ff, "frame end not on last beat of its cell")
   `BGCS_ASSERT_IMPL(a_pick_live, clock, reset, load, (remaining & pick) != 3'b000, "queue head with nothing left to send")

endmodule

// File: rtl/core/binary_grid_cellular_smoothing.sv
`timescale 1ns / 1ps
// One generation of a 3x3 wall/empty smoothing rule over a raster-ordered grid. A cell beat
// can be taken every clock while the queue has room, and the result port delivers one beat
// per clock while the receiver is ready. Each cell gives zero to three result beats. Row 0
// gives none. On an inner row, column 0 gives none, an inner position gives one and the row
// end gives two. On the last row each cell gives one more, so the last cell of the frame
// gives three. On inner rows the extra row-end result is taken up by the four-entry queue
// between classifier and result port, because the next row's first cell gives none, so
// cells flow at one per cycle while the receiver is ready. On the last row every cell but
// the first gives at least two results, so the queue fills and holds the input back there.
// The accepting edge loads the registered line memory read (two bits wide, MAX_WIDTH deep,
// written in the cycle after the read) and the stage-one registers; the classified cell is
// then pushed into the queue, and the output register is loaded from the queue head.
// Memory contents are not cleared at reset, and no result depends on an entry that the frame
// has not written. Writing grid_width or grid_height restarts the frame.
module binary_grid_cellular_smoothing #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [8:0] csr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cell_in_wall,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_cell_out_wall,
   output logic [7:0] rsp_out_col,
   output logic [7:0] rsp_out_row,
   output logic       rsp_last_of_run,
   output logic       rsp_frame_done
);
   import bgcs_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int QW    = $bits(item_info_type) + CW + RW;
   localparam int DEPTH = 4;

   logic          queue_room;
   logic          push;
   item_info_type push_info;
   logic [CW-1:0] push_col;
   logic [RW-1:0] push_row;
   logic          pop;
   logic          head_valid;
   logic [QW-1:0] head_data;
   item_info_type head_info;
   logic [CW-1:0] head_col;
   logic [RW-1:0] head_row;

   bgcs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CW         (CW),
      .RW         (RW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cell_in_wall (req_cell_in_wall),
      .queue_room       (queue_room),
      .push             (push),
      .push_info        (push_info),
      .push_col         (push_col),
      .push_row         (push_row)
   );

   bgcs_fifo #(
      .WIDTH (QW),
      .DEPTH (DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_info, push_col, push_row}),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .room       (queue_room)
   );

   assign {head_info, head_col, head_row} = head_data;

   bgcs_back #(
      .CW (CW),
      .RW (RW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_info         (head_info),
      .head_col          (head_col),
      .head_row          (head_row),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_out_wall (rsp_cell_out_wall),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_frame_done    (rsp_frame_done)
   );

endmodule

// File: sim/grid_smoothing_monitor.sv
`timescale 1ns / 1ps

module grid_smoothing_monitor #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [8:0] csr_data,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_cell_in_wall,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_cell_out_wall,
   input  logic [7:0] rsp_out_col,
   input  logic [7:0] rsp_out_row,
   input  logic       rsp_last_of_run,
   input  logic       rsp_frame_done,
   input  logic       test_done,
   output int         fail_count,
   output int         pending_count,
   output int         results_checked,
   output int         frames_seen
);

   import bgcs_pkg::*;

   typedef struct packed {
      logic       wall;
      logic [7:0] col;
      logic [7:0] row;
      logic       last;
      logic       done;
   } smoothed_cell_type;

   logic [8:0] width_reg;
   logic [8:0] height_reg;
   logic [3:0] death_reg;
   logic [3:0] birth_reg;
   logic       border_reg;

   bit         row_two[MAX_WIDTH];
   bit         row_one[MAX_WIDTH];
   int         col_pos;
   int         row_pos;
   logic [5:0] window;

   smoothed_cell_type pending_cells[$];
   bit                leftovers_reported;

   function automatic smoothed_cell_type make_cell(input logic wall, input int col, input int row);
      smoothed_cell_type c;
      c.wall = wall;
      c.col  = col[7:0];
      c.row  = row[7:0];
      c.last = 1'b0;
      c.done = 1'b0;
      return c;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      fail_count++;
   endtask

   task automatic restart_frame();
      col_pos = 0;
      row_pos = 0;
      window  = '0;
   endtask

   task automatic smooth_cell(input logic x);
      int                w;
      int                h;
      int                cnt;
      int                n;
      logic              top;
      logic              mid;
      logic              v;
      logic [2:0]        newcol;
      bit                frame_end;
      smoothed_cell_type outs[3];
      w = int'(width_reg);
      if (w < 3) w = 3;
      else if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = int'(height_reg);
      if (h < 3) h = 3;
      else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      top       = row_two[col_pos];
      mid       = row_one[col_pos];
      newcol    = {x, mid, top};
      n         = 0;
      frame_end = 0;

      // the beat completes the window centred one row up and one column left
      if (row_pos >= 1 && col_pos >= 1) begin
         if (row_pos == 1 || col_pos == 1) begin
            v = border_reg ? 1'b1 : window[4];
         end else begin
            cnt = $countones(window) + $countones(newcol);
            if (window[4]) v = (cnt < death_reg) ? 1'b0 : 1'b1;
            else v = (cnt > birth_reg) ? 1'b1 : 1'b0;
         end
         outs[n] = make_cell(v, col_pos - 1, row_pos - 1);
         n++;
      end
      if (row_pos >= 1 && col_pos == w - 1) begin
         outs[n] = make_cell(border_reg ? 1'b1 : mid, col_pos, row_pos - 1);
         n++;
      end
      if (row_pos == h - 1) begin
         outs[n] = make_cell(border_reg ? 1'b1 : x, col_pos, row_pos);
         n++;
      end

      row_two[col_pos] = mid;
      row_one[col_pos] = x;
      window = {newcol, window[5:3]};
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         window  = '0;
         row_pos++;
         if (row_pos >= h) begin
            row_pos   = 0;
            frame_end = 1;
            frames_seen++;
         end
      end

      if (n > 0) begin
         outs[n-1].last = 1'b1;
         outs[n-1].done = frame_end;
      end
      for (int i = 0; i < n; i++) pending_cells.insert(pending_cells.size(), outs[i]);
   endtask

   always @(posedge clock) begin
      smoothed_cell_type want;
      if (reset) begin
         width_reg          = GRID_WIDTH_RESET;
         height_reg         = GRID_HEIGHT_RESET;
         death_reg          = DEATH_BELOW_RESET;
         birth_reg          = BIRTH_ABOVE_RESET;
         border_reg         = FORCE_BORDER_RESET;
         fail_count         = 0;
         results_checked    = 0;
         frames_seen        = 0;
         leftovers_reported = 0;
         pending_cells.delete();
         restart_frame();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_WIDTH: begin
                  width_reg = csr_data;
                  restart_frame();
               end
               CSR_GRID_HEIGHT: begin
                  height_reg = csr_data;
                  restart_frame();
               end
               CSR_DEATH_BELOW:  death_reg  = csr_data[3:0];
               CSR_BIRTH_ABOVE:  birth_reg  = csr_data[3:0];
               CSR_FORCE_BORDER: border_reg = csr_data[0];
               default: ;
            endcase
         end

         // retire the result beat before predicting, so a new cell never pairs with it
         if (rsp_valid && rsp_ready) begin
            if (pending_cells.size() == 0) begin
               report_mismatch($sformatf("result beat at row %0d col %0d with nothing expected",
                                         rsp_out_row, rsp_out_col));
            end else begin
               want = pending_cells.pop_front();
               if (rsp_cell_out_wall !== want.wall)
                  report_mismatch($sformatf("cell (%0d,%0d) wall %b, expected %b",
                                            want.row, want.col, rsp_cell_out_wall, want.wall));
               if (rsp_out_col !== want.col)
                  report_mismatch($sformatf("cell (%0d,%0d) col %0d, expected %0d",
                                            want.row, want.col, rsp_out_col, want.col));
               if (rsp_out_row !== want.row)
                  report_mismatch($sformatf("cell (%0d,%0d) row %0d, expected %0d",
                                            want.row, want.col, rsp_out_row, want.row));
               if (rsp_last_of_run !== want.last)
                  report_mismatch($sformatf("cell (%0d,%0d) last_of_run %b, expected %b",
                                            want.row, want.col, rsp_last_of_run, want.last));
               if (rsp_frame_done !== want.done)
                  report_mismatch($sformatf("cell (%0d,%0d) frame_done %b, expected %b",
                                            want.row, want.col, rsp_frame_done, want.done));
               results_checked++;
            end
         end

         if (req_valid && req_ready) smooth_cell(req_cell_in_wall);

         if (test_done && !leftovers_reported) begin
            foreach (pending_cells[i])
               report_mismatch($sformatf("cell (%0d,%0d) never delivered",
                                         pending_cells[i].row, pending_cells[i].col));
            leftovers_reported = 1;
         end
      end
      pending_count = pending_cells.size();
   end

endmodule

// File: sim/binary_grid_cellular_smoothing_tb.sv
`timescale 1ns / 1ps

module binary_grid_cellular_smoothing_tb;

   import bgcs_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_CELLS  = 150;
   localparam int MAX_SIDE      = 256;

   logic       clock;
   logic       reset;
   logic       csr_valid;
   logic       csr_ready;
   logic [2:0] csr_index;
   logic [8:0] csr_data;
   logic       req_valid;
   logic       req_ready;
   logic       req_cell_in_wall;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_cell_out_wall;
   logic [7:0] rsp_out_col;
   logic [7:0] rsp_out_row;
   logic       rsp_last_of_run;
   logic       rsp_frame_done;
   logic       test_done;

   int fail_count;
   int pending_count;
   int results_checked;
   int frames_seen;

   int         burst_left;
   int         cells_sent;
   int         random_cells;
   int         phases;
   int         wait_cycles;
   int         stall_mode;
   int         stall_timer;
   logic [8:0] cur_width;
   logic [8:0] cur_height;

   binary_grid_cellular_smoothing u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cell_in_wall  (req_cell_in_wall),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_out_wall (rsp_cell_out_wall),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_frame_done    (rsp_frame_done)
   );

   grid_smoothing_monitor u_monitor (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cell_in_wall  (req_cell_in_wall),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_out_wall (rsp_cell_out_wall),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_frame_done    (rsp_frame_done),
      .test_done         (test_done),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .results_checked   (results_checked),
      .frames_seen       (frames_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("binary_grid_cellular_smoothing test failed");
      $finish;
   end

   // receiver: a changing mix of always ready, coin flips, sparse ready and a square wave
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= $urandom_range(0, 3);
         stall_timer <= $urandom_range(20, 120);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= stall_timer[2];
      endcase
   end

   function automatic int eff_size(input logic [8:0] raw);
      if (raw < 3) return 3;
      if (raw > MAX_SIDE) return MAX_SIDE;
      return int'(raw);
   endfunction

   function automatic logic [8:0] pick_size(input int typical_max);
      case ($urandom_range(0, 9))
         0:       return 9'($urandom_range(0, 2));
         1:       return 9'($urandom_range(9, 12));
         default: return 9'($urandom_range(3, typical_max));
      endcase
   endfunction

   function automatic logic [3:0] pick_threshold();
      case ($urandom_range(0, 5))
         0:       return 4'd0;
         1:       return 4'd9;
         2:       return 4'd15;
         default: return 4'($urandom_range(0, 10));
      endcase
   endfunction

   task automatic send_cell(input logic wall);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
      end
      req_valid        <= 1'b1;
      req_cell_in_wall <= wall;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      cells_sent++;
   endtask

   // hold off until every result is back, then let any row-0 beat drain out of the pipe
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [8:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   initial begin
      int wide;
      int tall;
      int cells;
      int density;

      reset            <= 1'b1;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_GRID_WIDTH;
      csr_data         <= '0;
      req_valid        <= 1'b0;
      req_cell_in_wall <= 1'b0;
      test_done        <= 1'b0;
      burst_left   = 0;
      cells_sent   = 0;
      random_cells = 0;
      phases       = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // undersized frame taken as 3x3, reset thresholds, border forced to walls
      cur_width  = 9'd0;
      cur_height = 9'd2;
      write_reg(CSR_GRID_WIDTH, cur_width);
      write_reg(CSR_GRID_HEIGHT, cur_height);
      csr_valid <= 1'b0;
      repeat (4) send_cell(1'b1);
      settle();
      // indexes past the last register must not disturb the frame
      for (int i = CSR_FORCE_BORDER + 1; i < 8; i++) write_reg(3'(i), 9'($urandom));
      csr_valid <= 1'b0;
      repeat (5) send_cell(1'b1);

      // border passed through, walls always die, nothing is born
      settle();
      write_reg(CSR_FORCE_BORDER, 9'h1FE);
      write_reg(CSR_DEATH_BELOW, 9'h1FF);
      write_reg(CSR_BIRTH_ABOVE, {5'h15, 4'd9});
      csr_valid <= 1'b0;
      repeat (2) send_cell(1'b0);
      settle();
      // size write part way through a frame restarts it
      cur_width = 9'd4;
      write_reg(CSR_GRID_WIDTH, cur_width);
      csr_valid <= 1'b0;
      for (int i = 0; i < 12; i++) send_cell(i != 6);

      // widest row clamped: the first row and the start of the next
      settle();
      cur_width  = 9'h1FF;
      cur_height = 9'd3;
      write_reg(CSR_GRID_WIDTH, cur_width);
      write_reg(CSR_GRID_HEIGHT, cur_height);
      write_reg(CSR_DEATH_BELOW, {5'h0A, DEATH_BELOW_RESET});
      write_reg(CSR_BIRTH_ABOVE, {5'h00, BIRTH_ABOVE_RESET});
      csr_valid <= 1'b0;
      repeat (MAX_SIDE + 8) send_cell(1'($urandom_range(0, 1)));

      // tallest frame clamped, only its first rows
      settle();
      cur_width  = 9'd3;
      cur_height = 9'd300;
      write_reg(CSR_GRID_WIDTH, cur_width);
      write_reg(CSR_GRID_HEIGHT, cur_height);
      write_reg(CSR_FORCE_BORDER, 9'h001);
      csr_valid <= 1'b0;
      repeat (3 * 10) send_cell(1'($urandom_range(0, 1)));

      while (random_cells < RANDOM_CELLS) begin
         settle();
         if (phases == 0 || $urandom_range(0, 3) != 0) begin
            cur_width = pick_size(8);
            write_reg(CSR_GRID_WIDTH, cur_width);
         end
         if (phases == 0 || $urandom_range(0, 3) != 0) begin
            cur_height = pick_size(6);
            write_reg(CSR_GRID_HEIGHT, cur_height);
         end
         if ($urandom_range(0, 1)) write_reg(CSR_DEATH_BELOW, {5'($urandom), pick_threshold()});
         if ($urandom_range(0, 1)) write_reg(CSR_BIRTH_ABOVE, {5'($urandom), pick_threshold()});
         if ($urandom_range(0, 1)) write_reg(CSR_FORCE_BORDER, 9'($urandom));
         if ($urandom_range(0, 7) == 0)
            write_reg(3'($urandom_range(CSR_FORCE_BORDER + 1, 7)), 9'($urandom));
         csr_valid <= 1'b0;
         phases++;

         wide  = eff_size(cur_width);
         tall  = eff_size(cur_height);
         cells = $urandom_range(1, 2) * wide * tall;
         if ($urandom_range(0, 2) == 0) cells += $urandom_range(1, wide * tall - 1);
         case ($urandom_range(0, 5))
            0:       density = 0;
            1:       density = 100;
            default: density = $urandom_range(10, 90);
         endcase
         repeat (cells) begin
            send_cell($urandom_range(0, 99) < density);
            if ($urandom_range(0, 79) == 0) settle();
         end
         random_cells += cells;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      test_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("%0d cells streamed, %0d of them over %0d random configuration phases",
               cells_sent, random_cells, phases);
      $display("%0d result beats compared, %0d frames completed", results_checked, frames_seen);
      if (fail_count == 0) begin
         $display("binary_grid_cellular_smoothing test passed");
      end else begin
         $display("binary_grid_cellular_smoothing test failed");
      end
      $finish;
   end

endmodule
